// ===== rtl/core/status_led_breathing_controller_assert.svh =====
// Assertion macros shared by the checker of the status LED breathing controller.
`ifndef STATUS_LED_BREATHING_CONTROLLER_ASSERT_SVH
`define STATUS_LED_BREATHING_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("status LED controller: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("status LED controller: next-cycle check failed");

`endif

// ===== rtl/core/slbc_pkg.sv =====
`default_nettype none

package slbc_pkg;

    localparam int DUTY_W     = 7;
    localparam int FRAC_W     = 16;
    localparam int COUNT_W    = 8;
    localparam int PCT_W      = 7;
    localparam int STATE_W    = 4;
    localparam int LEDS_W     = 3;
    localparam int MASK_W     = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;
    localparam int LUT_DEPTH  = 2 ** DUTY_W;

    localparam logic [DUTY_W-1:0]  DUTY_TOP           = 7'd100;
    localparam logic [DUTY_W-1:0]  DUTY_STEP          = 7'd2;
    localparam logic [STATE_W-1:0] BLINK_IMMUNE_STATE = 4'd3;

    localparam logic [COUNT_W-1:0] HOLD_TICKS_RST     = 8'd50;
    localparam logic [COUNT_W-1:0] REFRESH_PERIOD_RST = 8'd10;
    localparam logic [PCT_W-1:0]   LOW_LEVEL_RST      = 7'd10;
    localparam logic [PCT_W-1:0]   MID_LEVEL_RST      = 7'd30;
    localparam logic [COUNT_W-1:0] REFRESH_COUNT_RST  = 8'd1;

    localparam logic [LEDS_W-1:0] LEDS_OFF    = 3'h0;
    localparam logic [LEDS_W-1:0] LEDS_RED    = 3'h4;
    localparam logic [LEDS_W-1:0] LEDS_YELLOW = 3'h6;
    localparam logic [LEDS_W-1:0] LEDS_GREEN  = 3'h2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HOLD_TICKS     = 2'd0,
        CFG_REFRESH_PERIOD = 2'd1,
        CFG_LOW_LEVEL      = 2'd2,
        CFG_MID_LEVEL      = 2'd3
    } t_cfg_reg;

    typedef logic [FRAC_W-1:0] t_frac_lut [LUT_DEPTH];

    // Duty percent to 16-bit fraction, (duty*65536-1)/100 and zero for zero duty.
    function automatic t_frac_lut build_frac_lut();
        t_frac_lut   lut;
        logic [31:0] num;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            num = 32'(i) * 32'd65536 - 32'd1;
            lut[i] = (i == 0) ? '0 : FRAC_W'(num / DUTY_TOP);
        end
        return lut;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/status_led_breathing_controller.sv =====
// The result of an input transfer is on the output register in the next cycle.
// Throughput: one tick per cycle; a new tick is taken while the previous result
// waits, as long as the output register is empty or being drained that cycle.
// Reset (synchronous, active low) restores the configuration and counter reset
// values and empties the output register.
`default_nettype none

module status_led_breathing_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [slbc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [slbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Tick stream in.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: bt_connected[0], wifi_link[1], battery_valid[2], battery_percent[9:3],
    // cable_connected[10], battery_state[14:11], zero pad[15]
    input  wire logic [slbc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // Result stream out.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: effect_update[0], channel_mask[3:1], duty_fraction[19:4],
    // status_update[20], status_leds[23:21]
    output logic [slbc_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    localparam slbc_pkg::t_frac_lut FracLut = slbc_pkg::build_frac_lut();

    // Configuration registers.
    logic [slbc_pkg::COUNT_W-1:0] r_hold_ticks;
    logic [slbc_pkg::COUNT_W-1:0] r_refresh_period;
    logic [slbc_pkg::PCT_W-1:0]   r_low_level;
    logic [slbc_pkg::PCT_W-1:0]   r_mid_level;

    // Tick state.
    logic [slbc_pkg::COUNT_W-1:0] r_hold_count,    n_hold_count;
    logic [slbc_pkg::DUTY_W-1:0]  r_duty_level,    n_duty_level;
    logic                         r_ramp_up,       n_ramp_up;
    logic [slbc_pkg::COUNT_W-1:0] r_refresh_count, n_refresh_count;
    logic                         r_blink_phase,   n_blink_phase;

    // Output register.
    logic                            r_out_valid;
    logic [slbc_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                          in_accept;
    logic                          in_bt;
    logic                          in_wifi;
    logic                          in_valid;
    logic [slbc_pkg::PCT_W-1:0]    in_pct;
    logic                          in_cable;
    logic [slbc_pkg::STATE_W-1:0]  in_bstate;

    logic                          eff_upd;
    logic [slbc_pkg::MASK_W-1:0]   mask;
    logic [slbc_pkg::FRAC_W-1:0]   frac;
    logic                          st_upd;
    logic [slbc_pkg::LEDS_W-1:0]   leds;
    logic [slbc_pkg::LEDS_W-1:0]   colour;
    logic [slbc_pkg::COUNT_W-1:0]  refresh_dec;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign in_bt     = i_s_axis_tdata[0];
    assign in_wifi   = i_s_axis_tdata[1];
    assign in_valid  = i_s_axis_tdata[2];
    assign in_pct    = i_s_axis_tdata[9:3];
    assign in_cable  = i_s_axis_tdata[10];
    assign in_bstate = i_s_axis_tdata[14:11];

    // Breathing effect: the duty reverses at either end of the triangle.
    always_comb begin
        n_hold_count = r_hold_count;
        n_duty_level = r_duty_level;
        n_ramp_up    = r_ramp_up;
        eff_upd      = 1'b0;
        mask         = '0;
        frac         = '0;
        if (r_hold_count == '0) begin
            if (r_duty_level == '0 || r_duty_level == slbc_pkg::DUTY_TOP) begin
                n_ramp_up = !r_ramp_up;
            end
            if (n_ramp_up) begin
                n_duty_level = r_duty_level + slbc_pkg::DUTY_STEP;
            end else if (r_duty_level >= slbc_pkg::DUTY_STEP) begin
                n_duty_level = r_duty_level - slbc_pkg::DUTY_STEP;
            end else begin
                n_duty_level = '0;
            end
            eff_upd = 1'b1;
            mask    = {1'b1, in_wifi, in_bt};
            frac    = FracLut[n_duty_level];
            if (n_duty_level == '0) begin
                n_hold_count = r_hold_ticks;
            end
        end else begin
            n_hold_count = r_hold_count - 1'b1;
        end
    end

    // Battery LED set: a refresh period of zero wraps the counter to 256 ticks.
    always_comb begin
        refresh_dec     = r_refresh_count - 1'b1;
        n_refresh_count = refresh_dec;
        n_blink_phase   = r_blink_phase;
        st_upd          = 1'b0;
        leds            = slbc_pkg::LEDS_OFF;
        if (in_pct < r_low_level) begin
            colour = slbc_pkg::LEDS_RED;
        end else if (in_pct < r_mid_level) begin
            colour = slbc_pkg::LEDS_YELLOW;
        end else begin
            colour = slbc_pkg::LEDS_GREEN;
        end
        if (refresh_dec == '0) begin
            n_refresh_count = r_refresh_period;
            st_upd          = 1'b1;
            if (!in_valid) begin
                leds = slbc_pkg::LEDS_YELLOW;
            end else if (r_blink_phase && in_cable &&
                         in_bstate != slbc_pkg::BLINK_IMMUNE_STATE) begin
                leds          = slbc_pkg::LEDS_OFF;
                n_blink_phase = 1'b0;
            end else begin
                leds          = colour;
                n_blink_phase = 1'b1;
            end
        end
    end

    assign n_out_data = {leds, st_upd, frac, mask, eff_upd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks     <= slbc_pkg::HOLD_TICKS_RST;
            r_refresh_period <= slbc_pkg::REFRESH_PERIOD_RST;
            r_low_level      <= slbc_pkg::LOW_LEVEL_RST;
            r_mid_level      <= slbc_pkg::MID_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (slbc_pkg::t_cfg_reg'(i_cfg_addr))
                slbc_pkg::CFG_HOLD_TICKS: begin
                    r_hold_ticks <= i_cfg_data;
                end
                slbc_pkg::CFG_REFRESH_PERIOD: begin
                    r_refresh_period <= i_cfg_data;
                end
                slbc_pkg::CFG_LOW_LEVEL: begin
                    r_low_level <= i_cfg_data[slbc_pkg::PCT_W-1:0];
                end
                slbc_pkg::CFG_MID_LEVEL: begin
                    r_mid_level <= i_cfg_data[slbc_pkg::PCT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_count    <= slbc_pkg::HOLD_TICKS_RST;
            r_duty_level    <= slbc_pkg::DUTY_TOP;
            r_ramp_up       <= 1'b1;
            r_refresh_count <= slbc_pkg::REFRESH_COUNT_RST;
            r_blink_phase   <= 1'b0;
            r_out_valid     <= 1'b0;
        end else if (in_accept) begin
            r_hold_count    <= n_hold_count;
            r_duty_level    <= n_duty_level;
            r_ramp_up       <= n_ramp_up;
            r_refresh_count <= n_refresh_count;
            r_blink_phase   <= n_blink_phase;
            r_out_valid     <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/slbc_checker.sv =====
`default_nettype none

`include "status_led_breathing_controller_assert.svh"

module slbc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_s_axis_tvalid,
    input wire logic o_s_axis_tready,
    input wire logic o_m_axis_tvalid,
    input wire logic i_m_axis_tready,
    input wire logic [slbc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    // A result held back by the sink keeps its contents.
    `SLBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // Every accepted tick produces a result in the next cycle.
    `SLBC_ASSERT_NEXT(a_tick_result, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, o_m_axis_tvalid)

    // An empty output register never refuses a tick.
    `SLBC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)

    // Without an effect update the mask and duty are zero.
    `SLBC_ASSERT_NOW(a_effect_quiet, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[0], o_m_axis_tdata[19:1] == '0)

    // Without a refresh the LED set is off.
    `SLBC_ASSERT_NOW(a_status_quiet, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[20], o_m_axis_tdata[23:21] == '0)

endmodule

bind status_led_breathing_controller slbc_checker u_slbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
